>>> design/wsdefr_pkg.sv
// Shared types and codes for the WebSocket frame deframer.
package wsdefr_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_PING  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic       present;
    logic       frame_end;
    logic       message_end;
  } res_t;

endpackage

>>> design/websocket_frame_deframer.sv
// WebSocket frame deframer: parses received bytes into unmasked payload and events.
//
//  channel   | dir | tdata                          | tuser                     | tlast
//  s_axis    | in  | [7:0] rx_byte                  | -                         | -
//  m_axis    | out | [7:0] out_byte, [8] message_end| [1:0] out_kind, [2] present| frame_end
//
// One byte per clock sustained unless a stalled result blocks a new one; a byte passes from
// the input register through the parse logic into the result register.
// The 64-bit remaining-length decrement and zero test set the parse path.
// Reset clears the parser to await the first header byte and empties both registers.
// A stalled result holds while the input register still takes a byte; bytes with no result
// (pong, non-last close/error payload, header bytes not ending an empty frame) still advance.
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] message_end, [15:9] zero
  output logic [2:0]  m_axis_tuser,   // [1:0] out_kind, [2] byte_present
  output logic        m_axis_tlast    // frame_end
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;

  // parser state
  wsdefr_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hcnt_q, hcnt_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        final_q, final_d;
  logic        masked_q, masked_d;
  logic [63:0] remain_q, remain_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  kpos_q, kpos_d;

  // result register
  logic             out_valid_q, out_valid_d;
  wsdefr_pkg::res_t out_q;

  wsdefr_pkg::res_t res;
  logic             advance;
  logic             len_done;
  logic             hdr_done;
  logic [3:0]       hcnt_dec;
  logic [63:0]      remain_dec;
  logic             last;
  logic [7:0]       key_byte;
  logic             is_data;

  function automatic wsdefr_pkg::res_t make_res(wsdefr_pkg::kind_e kind, logic [7:0] data,
                                                logic present, logic fend, logic mend);
    wsdefr_pkg::res_t r;
    r.valid       = 1'b1;
    r.kind        = kind;
    r.data        = data;
    r.present     = present;
    r.frame_end   = fend;
    r.message_end = mend;
    return r;
  endfunction

  always_comb begin
    case (opcode_q) inside
      wsdefr_pkg::OP_CONT, wsdefr_pkg::OP_TEXT, wsdefr_pkg::OP_BIN: is_data = 1'b1;
      default: is_data = 1'b0;
    endcase
  end

  always_comb begin
    case (kpos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign hcnt_dec   = (hcnt_q != 4'd0) ? hcnt_q - 4'd1 : hcnt_q;
  assign remain_dec = (remain_q != 64'd0) ? remain_q - 64'd1 : remain_q;
  assign last       = (remain_dec == 64'd0);

  always_comb begin
    phase_d  = phase_q;
    hcnt_d   = hcnt_q;
    opcode_d = opcode_q;
    final_d  = final_q;
    masked_d = masked_q;
    remain_d = remain_q;
    key_d    = key_q;
    kpos_d   = kpos_q;
    res      = '0;
    len_done = 1'b0;
    hdr_done = 1'b0;

    unique case (phase_q)
      wsdefr_pkg::PH_HDR1: begin
        masked_d = in_byte_q[7];
        key_d    = '0;
        kpos_d   = 2'd0;
        remain_d = '0;
        if (in_byte_q[6:0] == wsdefr_pkg::LEN_EXT16) begin
          hcnt_d  = wsdefr_pkg::EXT16_BYTES;
          phase_d = wsdefr_pkg::PH_EXTLEN;
        end else if (in_byte_q[6:0] == wsdefr_pkg::LEN_EXT64) begin
          hcnt_d  = wsdefr_pkg::EXT64_BYTES;
          phase_d = wsdefr_pkg::PH_EXTLEN;
        end else begin
          remain_d = {57'd0, in_byte_q[6:0]};
          len_done = 1'b1;
        end
      end
      wsdefr_pkg::PH_EXTLEN: begin
        remain_d = {remain_q[55:0], in_byte_q};
        hcnt_d   = hcnt_dec;
        len_done = (hcnt_dec == 4'd0);
      end
      wsdefr_pkg::PH_KEY: begin
        key_d    = {key_q[23:0], in_byte_q};
        hcnt_d   = hcnt_dec;
        hdr_done = (hcnt_dec == 4'd0);
      end
      wsdefr_pkg::PH_PAYLOAD: begin
        kpos_d   = kpos_q + 2'd1;
        remain_d = remain_dec;
        if (last) begin
          phase_d = wsdefr_pkg::PH_HDR0;
        end
        if (is_data) begin
          res = make_res(wsdefr_pkg::KIND_DATA, in_byte_q ^ key_byte, 1'b1, last,
                         last & final_q);
        end else if (opcode_q == wsdefr_pkg::OP_PING) begin
          res = make_res(wsdefr_pkg::KIND_PING, in_byte_q ^ key_byte, 1'b1, last, 1'b0);
        end else if (opcode_q == wsdefr_pkg::OP_PONG || !last) begin
          res = '0;
        end else if (opcode_q == wsdefr_pkg::OP_CLOSE) begin
          res = make_res(wsdefr_pkg::KIND_CLOSE, 8'd0, 1'b0, 1'b1, 1'b0);
        end else begin
          res = make_res(wsdefr_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b1, 1'b0);
        end
      end
      default: begin
        final_d  = in_byte_q[7];
        opcode_d = in_byte_q[3:0];
        phase_d  = wsdefr_pkg::PH_HDR1;
      end
    endcase

    // length known: fetch the key or finish the header
    if (len_done) begin
      if (masked_d) begin
        hcnt_d  = wsdefr_pkg::KEY_BYTES;
        phase_d = wsdefr_pkg::PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // header complete: start payload or close an empty frame
    if (hdr_done) begin
      kpos_d = 2'd0;
      if (remain_d != 64'd0) begin
        phase_d = wsdefr_pkg::PH_PAYLOAD;
      end else begin
        phase_d = wsdefr_pkg::PH_HDR0;
        if (is_data) begin
          res = make_res(wsdefr_pkg::KIND_DATA, 8'd0, 1'b0, 1'b1, final_q);
        end else if (opcode_q == wsdefr_pkg::OP_PING) begin
          res = make_res(wsdefr_pkg::KIND_PING, 8'd0, 1'b0, 1'b1, 1'b0);
        end else if (opcode_q == wsdefr_pkg::OP_PONG) begin
          res = '0;
        end else if (opcode_q == wsdefr_pkg::OP_CLOSE) begin
          res = make_res(wsdefr_pkg::KIND_CLOSE, 8'd0, 1'b0, 1'b1, 1'b0);
        end else begin
          res = make_res(wsdefr_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b1, 1'b0);
        end
      end
    end
  end

  // parse the held byte unless its result would overwrite a waiting one
  assign advance = in_valid_q & (~res.valid | ~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
    out_valid_d = out_valid_q;
    if (advance && res.valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= wsdefr_pkg::PH_HDR0;
      hcnt_q      <= '0;
      opcode_q    <= '0;
      final_q     <= 1'b0;
      masked_q    <= 1'b0;
      remain_q    <= '0;
      key_q       <= '0;
      kpos_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        phase_q  <= phase_d;
        hcnt_q   <= hcnt_d;
        opcode_q <= opcode_d;
        final_q  <= final_d;
        masked_q <= masked_d;
        remain_q <= remain_d;
        key_q    <= key_d;
        kpos_q   <= kpos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.message_end, out_q.data};
  assign m_axis_tuser  = {out_q.present, out_q.kind};
  assign m_axis_tlast  = out_q.frame_end;

  a_byteless_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.present |-> out_q.data == 8'd0)
    else $error("byteless result carries data");

  a_msg_end_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.message_end |-> out_q.frame_end && out_q.kind == wsdefr_pkg::KIND_DATA)
    else $error("message end outside a data frame end");

  a_present_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.present |->
      out_q.kind == wsdefr_pkg::KIND_DATA || out_q.kind == wsdefr_pkg::KIND_PING)
    else $error("payload byte on an event result");

  a_payload_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsdefr_pkg::PH_PAYLOAD |-> remain_q != 64'd0)
    else $error("payload phase with no bytes remaining");

  a_hdr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsdefr_pkg::PH_EXTLEN || phase_q == wsdefr_pkg::PH_KEY |-> hcnt_q != 4'd0)
    else $error("header phase with no bytes due");

endmodule

>>> test/tb_top.sv
// Testbench for the WebSocket frame deframer: directed frames, then random frames.
`timescale 1ns / 1ps

module tb_top;

  localparam int HALF_PERIOD_NS = 5;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_BYTES   = 1400;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 10;
  localparam int TIMEOUT_NS     = 5_000_000;
  localparam int DIRECTED_ROWS  = 26;

  typedef struct packed {
    wsdefr_pkg::kind_e kind;
    logic [7:0]        data;
    logic              present;
    logic              frame_end;
    logic              message_end;
  } deframed_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic       emits;
    deframed_t  res;
  } stim_row_t;

  localparam deframed_t NONE_RES = '{wsdefr_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0, 1'b0};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Parser state of the predictor
  wsdefr_pkg::phase_e prs_phase;
  logic [3:0]  hdr_left;
  logic [3:0]  cur_op;
  logic        cur_fin;
  logic        cur_masked;
  logic [63:0] payload_left;
  logic [31:0] unmask_key;
  logic [1:0]  key_idx;

  deframed_t pending_deframed[$];
  int        error_count;
  int        bytes_sent;
  int        sender_idle_pct;
  int        recv_stall_pct;
  int        hold_requests;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // empty final text frame
    '{8'h81, 1'b1, 1'b0, NONE_RES},
    '{8'h00, 1'b1, 1'b1, '{wsdefr_pkg::KIND_DATA, 8'h00, 1'b0, 1'b1, 1'b1}},
    // empty ping without fin
    '{8'h09, 1'b1, 1'b0, NONE_RES},
    '{8'h00, 1'b1, 1'b1, '{wsdefr_pkg::KIND_PING, 8'h00, 1'b0, 1'b1, 1'b0}},
    // empty pong is dropped
    '{8'h8A, 1'b1, 1'b0, NONE_RES},
    '{8'h00, 1'b1, 1'b0, NONE_RES},
    // empty close with reserved bits set
    '{8'hF8, 1'b1, 1'b0, NONE_RES},
    '{8'h00, 1'b1, 1'b1, '{wsdefr_pkg::KIND_CLOSE, 8'h00, 1'b0, 1'b1, 1'b0}},
    // empty frame with unknown opcode
    '{8'h83, 1'b1, 1'b0, NONE_RES},
    '{8'h00, 1'b1, 1'b1, '{wsdefr_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b0}},
    // masked binary frame without fin, all-ones key
    '{8'h02, 1'b1, 1'b0, NONE_RES},
    '{8'h82, 1'b1, 1'b0, NONE_RES},
    '{8'hFF, 1'b1, 1'b0, NONE_RES},
    '{8'hFF, 1'b1, 1'b0, NONE_RES},
    '{8'hFF, 1'b1, 1'b0, NONE_RES},
    '{8'hFF, 1'b1, 1'b0, NONE_RES},
    '{8'h00, 1'b1, 1'b1, '{wsdefr_pkg::KIND_DATA, 8'hFF, 1'b1, 1'b0, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{wsdefr_pkg::KIND_DATA, 8'h00, 1'b1, 1'b1, 1'b0}},
    // final continuation with 16-bit length
    '{8'h80, 1'b0, 1'b0, NONE_RES},
    '{8'h7E, 1'b0, 1'b0, NONE_RES},
    '{8'h00, 1'b0, 1'b0, NONE_RES},
    '{8'h01, 1'b0, 1'b0, NONE_RES},
    '{8'hAB, 1'b0, 1'b0, NONE_RES},
    // close with payload: event on the last byte
    '{8'h88, 1'b1, 1'b0, NONE_RES},
    '{8'h01, 1'b1, 1'b0, NONE_RES},
    '{8'h55, 1'b1, 1'b1, '{wsdefr_pkg::KIND_CLOSE, 8'h00, 1'b0, 1'b1, 1'b0}}
  };

  websocket_frame_deframer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #HALF_PERIOD_NS clk_i = ~clk_i;

  function automatic bit is_data_op(input logic [3:0] op);
    return op == wsdefr_pkg::OP_CONT || op == wsdefr_pkg::OP_TEXT ||
           op == wsdefr_pkg::OP_BIN;
  endfunction

  function automatic bit close_header(output deframed_t res);
    res = NONE_RES;
    key_idx = 2'd0;
    if (payload_left != 64'd0) begin
      prs_phase = wsdefr_pkg::PH_PAYLOAD;
      return 1'b0;
    end
    prs_phase = wsdefr_pkg::PH_HDR0;
    res.frame_end = 1'b1;
    if (is_data_op(cur_op)) begin
      res.message_end = cur_fin;
    end else if (cur_op == wsdefr_pkg::OP_PING) begin
      res.kind = wsdefr_pkg::KIND_PING;
    end else if (cur_op == wsdefr_pkg::OP_PONG) begin
      return 1'b0;
    end else if (cur_op == wsdefr_pkg::OP_CLOSE) begin
      res.kind = wsdefr_pkg::KIND_CLOSE;
    end else begin
      res.kind = wsdefr_pkg::KIND_ERROR;
    end
    return 1'b1;
  endfunction

  function automatic bit close_length(output deframed_t res);
    res = NONE_RES;
    if (cur_masked) begin
      hdr_left  = wsdefr_pkg::KEY_BYTES;
      prs_phase = wsdefr_pkg::PH_KEY;
      return 1'b0;
    end
    return close_header(res);
  endfunction

  // Advance the parser by one received byte; return 1 when a result is due.
  function automatic bit deframe_step(input logic [7:0] rx, output deframed_t res);
    logic [7:0] plain;
    logic       last;
    res = NONE_RES;
    case (prs_phase)
      wsdefr_pkg::PH_HDR1: begin
        cur_masked   = rx[7];
        unmask_key   = '0;
        key_idx      = 2'd0;
        payload_left = '0;
        if (rx[6:0] < wsdefr_pkg::LEN_EXT16) begin
          payload_left = 64'(rx[6:0]);
          return close_length(res);
        end
        hdr_left  = (rx[6:0] == wsdefr_pkg::LEN_EXT16) ? wsdefr_pkg::EXT16_BYTES
                                                       : wsdefr_pkg::EXT64_BYTES;
        prs_phase = wsdefr_pkg::PH_EXTLEN;
        return 1'b0;
      end
      wsdefr_pkg::PH_EXTLEN: begin
        payload_left = {payload_left[55:0], rx};
        if (hdr_left != 4'd0) hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) return close_length(res);
        return 1'b0;
      end
      wsdefr_pkg::PH_KEY: begin
        unmask_key = {unmask_key[23:0], rx};
        if (hdr_left != 4'd0) hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) return close_header(res);
        return 1'b0;
      end
      wsdefr_pkg::PH_PAYLOAD: begin
        plain   = rx ^ unmask_key[31 - 8 * key_idx -: 8];
        key_idx = key_idx + 2'd1;
        if (payload_left != 64'd0) payload_left = payload_left - 64'd1;
        last = (payload_left == 64'd0);
        if (last) prs_phase = wsdefr_pkg::PH_HDR0;
        res.frame_end = last;
        if (is_data_op(cur_op)) begin
          res.data        = plain;
          res.present     = 1'b1;
          res.message_end = last & cur_fin;
          return 1'b1;
        end
        if (cur_op == wsdefr_pkg::OP_PING) begin
          res.kind    = wsdefr_pkg::KIND_PING;
          res.data    = plain;
          res.present = 1'b1;
          return 1'b1;
        end
        if (cur_op == wsdefr_pkg::OP_PONG || !last) return 1'b0;
        res.kind = (cur_op == wsdefr_pkg::OP_CLOSE) ? wsdefr_pkg::KIND_CLOSE
                                                    : wsdefr_pkg::KIND_ERROR;
        return 1'b1;
      end
      default: begin
        cur_fin   = rx[7];
        cur_op    = rx[3:0];
        prs_phase = wsdefr_pkg::PH_HDR1;
        return 1'b0;
      end
    endcase
  endfunction

  // Offer one byte, wait for the handshake, then record what it should produce.
  task automatic send_byte(input logic [7:0] rx, input bit typed = 1'b0,
                           input bit typed_emits = 1'b0,
                           input deframed_t typed_res = NONE_RES);
    deframed_t res;
    bit        emits;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    do @(posedge clk_i); while (!s_axis_tready);
    emits = deframe_step(rx, res);
    if (typed) begin
      emits = typed_emits;
      res   = typed_res;
    end
    if (emits) pending_deframed.push_back(res);
    bytes_sent++;
  endtask

  // Build one frame with random content; some carry header-like payload bytes.
  task automatic send_frame();
    logic [3:0]  op;
    logic        masked;
    logic [63:0] len;
    logic [31:0] key;
    logic [7:0]  pay;
    int          pick;
    int          form;
    bit          tangled;
    pick = $urandom_range(0, 99);
    if (pick < 14)      op = wsdefr_pkg::OP_CONT;
    else if (pick < 28) op = wsdefr_pkg::OP_TEXT;
    else if (pick < 42) op = wsdefr_pkg::OP_BIN;
    else if (pick < 52) op = wsdefr_pkg::OP_CLOSE;
    else if (pick < 66) op = wsdefr_pkg::OP_PING;
    else if (pick < 78) op = wsdefr_pkg::OP_PONG;
    else                op = 4'($urandom_range(0, 15));
    masked  = 1'($urandom);
    tangled = ($urandom_range(0, 99) < 12);
    form    = $urandom_range(0, 99);
    if (form < 70)      len = 64'($urandom_range(0, 12));
    else if (form < 76) len = 64'($urandom_range(13, 125));
    else if (form < 90) len = ($urandom_range(0, 19) == 0) ? 64'($urandom_range(126, 300))
                                                           : 64'($urandom_range(0, 60));
    else                len = 64'($urandom_range(0, 40));
    send_byte({1'($urandom), 3'($urandom), op});
    if (form < 76) begin
      send_byte({masked, len[6:0]});
    end else if (form < 90) begin
      send_byte({masked, wsdefr_pkg::LEN_EXT16});
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else begin
      send_byte({masked, wsdefr_pkg::LEN_EXT64});
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end
    if (masked) begin
      key = $urandom;
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    end
    for (longint i = 0; i < longint'(len); i++) begin
      pay = 8'($urandom);
      if (tangled) begin
        case ($urandom_range(0, 4))
          0: pay = 8'h81;
          1: pay = 8'h7F;
          2: pay = 8'h7E;
          3: pay = 8'h88;
          default: ;
        endcase
      end
      send_byte(pay);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_deframed.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_monitor
    deframed_t got;
    deframed_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind        = wsdefr_pkg::kind_e'(m_axis_tuser[1:0]);
      got.data        = m_axis_tdata[7:0];
      got.present     = m_axis_tuser[2];
      got.frame_end   = m_axis_tlast;
      got.message_end = m_axis_tdata[8];
      if (pending_deframed.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
        error_count++;
      end else begin
        want = pending_deframed.pop_front();
        check_field("out_kind", 8'(want.kind), 8'(got.kind));
        check_field("out_byte", want.data, got.data);
        check_field("byte_present", 8'(want.present), 8'(got.present));
        check_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
        check_field("message_end", 8'(want.message_end), 8'(got.message_end));
      end
    end
  end

  // Drive ready; a hold-off request keeps it low for a long stretch.
  initial begin : result_sink
    int hold_served;
    int hold_left;
    hold_served   = 0;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin : run_limit
    #TIMEOUT_NS;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int idle_sets [4][2];
    int target;
    idle_sets       = '{'{0, 0}, '{71, 0}, '{0, 71}, '{9, 9}};
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    error_count     = 0;
    bytes_sent      = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_requests   = 0;
    prs_phase       = wsdefr_pkg::PH_HDR0;
    hdr_left        = '0;
    cur_op          = '0;
    cur_fin         = 1'b0;
    cur_masked      = 1'b0;
    payload_left    = '0;
    unmask_key      = '0;
    key_idx         = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].emits,
                directed_rows[i].res);
    end
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_sets[ph][0];
      recv_stall_pct  = idle_sets[ph][1];
      // Stall the sink while the source keeps pushing to back up the input.
      if (ph == 0) hold_requests++;
      target = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < target) send_frame();
      // Hold the source until every pending result has drained.
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
